[rtl/ip_rule_classifier_core_defines.svh]
// Assertion macros used by the classifier checker.
`ifndef IP_RULE_CLASSIFIER_CORE_DEFINES_SVH
`define IP_RULE_CLASSIFIER_CORE_DEFINES_SVH

// Check that cons holds in the cycle where ante holds.
`define IPRC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("classifier check failed");

// Check that cons holds once the delay dly has passed after ante.
`define IPRC_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("classifier timing check failed");

`endif

[rtl/iprc_pkg.sv]
package iprc_pkg;

   localparam int SLOT_W     = 4;
   localparam int SLOT_COUNT = 2 ** SLOT_W;
   localparam int ADDR_W     = 32;
   localparam int CLASS_W    = 3;
   localparam int AREA_W     = 2;

   localparam logic REQ_CLASSIFY = 1'b0;
   localparam logic REQ_WRITE    = 1'b1;

   localparam logic [CLASS_W-1:0] CLASS_OUTSIDE      = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_FIRST_CAMPUS  = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_SECOND_CAMPUS = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_UNUSED_CAMPUS = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_UNKNOWN      = 3'd4;

   localparam logic [AREA_W-1:0] AREA_FIRST  = 2'd0;
   localparam logic [AREA_W-1:0] AREA_SECOND = 2'd1;
   localparam logic [AREA_W-1:0] AREA_UNUSED = 2'd2;

   typedef struct packed {
      logic              req_type;
      logic [SLOT_W-1:0] rule_index;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] rule_mask;
      logic [ADDR_W-1:0] rule_match;
      logic [ADDR_W-1:0] range_low;
      logic [ADDR_W-1:0] range_high;
      logic              rule_ranged;
      logic [AREA_W-1:0] rule_area;
      logic              rule_valid;
   } req_item_type;

   typedef struct packed {
      logic [CLASS_W-1:0] class_code;
      logic               matched;
      logic [SLOT_W-1:0]  matched_rule;
   } rsp_item_type;

   // One item moving down the cell chain, with the first hit found so far.
   typedef struct packed {
      logic              valid;
      req_item_type      item;
      logic              hit;
      logic [SLOT_W-1:0] hit_slot;
      logic [AREA_W-1:0] hit_area;
   } stage_type;

   function automatic logic [CLASS_W-1:0] area_to_class(input logic [AREA_W-1:0] area);
      logic [CLASS_W-1:0] cls;
      unique case (area)
         AREA_FIRST:  cls = CLASS_FIRST_CAMPUS;
         AREA_SECOND: cls = CLASS_SECOND_CAMPUS;
         AREA_UNUSED: cls = CLASS_UNUSED_CAMPUS;
         default:     cls = CLASS_UNKNOWN;
      endcase
      return cls;
   endfunction

endpackage

[rtl/iprc_cell.sv]
// One rule slot: holds the rule, tests the passing item, hands it on.
module iprc_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  iprc_pkg::stage_type up_link,
   output iprc_pkg::stage_type down_link
);

   localparam bit WRITABLE = CELL_INDEX < iprc_pkg::SLOT_COUNT;
   localparam logic [iprc_pkg::SLOT_W-1:0] SLOT = iprc_pkg::SLOT_W'(CELL_INDEX);

   logic [iprc_pkg::ADDR_W-1:0] mask_ff;
   logic [iprc_pkg::ADDR_W-1:0] match_ff;
   logic [iprc_pkg::ADDR_W-1:0] low_ff;
   logic [iprc_pkg::ADDR_W-1:0] high_ff;
   logic                        ranged_ff;
   logic [iprc_pkg::AREA_W-1:0] area_ff;
   logic                        valid_ff;

   iprc_pkg::stage_type pipe_ff;
   iprc_pkg::stage_type pipe_in;
   logic                pipe_valid_ff;

   logic write_here;
   logic rule_hit;

   assign write_here = WRITABLE && up_link.valid &&
                       (up_link.item.req_type == iprc_pkg::REQ_WRITE) &&
                       (up_link.item.rule_index == SLOT);

   assign rule_hit = valid_ff &&
                     ((up_link.item.address & mask_ff) == match_ff) &&
                     (!ranged_ff || ((up_link.item.address >= low_ff) &&
                                     (up_link.item.address <= high_ff)));

   always_comb begin
      pipe_in = up_link;
      if (up_link.valid && (up_link.item.req_type == iprc_pkg::REQ_CLASSIFY) &&
          !up_link.hit && rule_hit) begin
         pipe_in.hit      = 1'b1;
         pipe_in.hit_slot = SLOT;
         pipe_in.hit_area = area_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (write_here) begin
         mask_ff   <= up_link.item.rule_mask;
         match_ff  <= up_link.item.rule_match;
         low_ff    <= up_link.item.range_low;
         high_ff   <= up_link.item.range_high;
         ranged_ff <= up_link.item.rule_ranged;
         area_ff   <= up_link.item.rule_area;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (write_here) begin
         valid_ff <= up_link.item.rule_valid;
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff <= pipe_in;
   end

   // Drop items in flight on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= pipe_in.valid;
      end
   end

   always_comb begin
      down_link       = pipe_ff;
      down_link.valid = pipe_valid_ff;
   end

endmodule

[rtl/ip_rule_classifier_core.sv]
// Each item is registered in every rule cell and then in the output registers.
// Throughput: one transfer per cycle unless busy; the item passes one rule cell per cycle.
// busy is high only from a reset edge until the first edge after reset drops.
// Reset (synchronous, active high) clears every rule to invalid and drops items in flight.
// The receiver cannot stall: rsp_strobe marks each result for exactly one cycle.
module ip_rule_classifier_core #(
   parameter int RULE_COUNT = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  iprc_pkg::req_item_type req_data,
   output logic                   rsp_strobe,
   output iprc_pkg::rsp_item_type rsp_data
);

   // Link k feeds cell k; link RULE_COUNT leaves the last cell.
   iprc_pkg::stage_type chain [RULE_COUNT+1];
   iprc_pkg::stage_type head;

   logic                   busy_ff;
   logic                   strobe_ff;
   iprc_pkg::rsp_item_type rsp_ff;
   iprc_pkg::rsp_item_type rsp_in;

   // Inject the accepted transfer at the head of the chain with no hit yet.
   always_comb begin
      head.valid    = start && !busy_ff;
      head.item     = req_data;
      head.hit      = 1'b0;
      head.hit_slot = '0;
      head.hit_area = '0;
   end

   assign chain[0] = head;

   // A write reaches cell k ahead of every later transfer, so every
   // later classify sees the updated rule; first hit wins as it moves down.
   for (genvar k = 0; k < RULE_COUNT; k++) begin : g_cell
      iprc_cell #(
         .CELL_INDEX(k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_link  (chain[k]),
         .down_link(chain[k+1])
      );
   end

   // Build the result from the chain tail: writes report zeros, a zero
   // address is unknown regardless of hits, no hit reports outside.
   always_comb begin
      rsp_in.class_code   = iprc_pkg::CLASS_OUTSIDE;
      rsp_in.matched      = 1'b0;
      rsp_in.matched_rule = '0;
      if (chain[RULE_COUNT].item.req_type == iprc_pkg::REQ_CLASSIFY) begin
         if (chain[RULE_COUNT].item.address == '0) begin
            rsp_in.class_code = iprc_pkg::CLASS_UNKNOWN;
         end else if (chain[RULE_COUNT].hit) begin
            rsp_in.class_code   = iprc_pkg::area_to_class(chain[RULE_COUNT].hit_area);
            rsp_in.matched      = 1'b1;
            rsp_in.matched_rule = chain[RULE_COUNT].hit_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Hold busy across reset; release it on the clock edge that first sees reset low.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         busy_ff   <= 1'b1;
      end else begin
         strobe_ff <= chain[RULE_COUNT].valid;
         busy_ff   <= 1'b0;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[rtl/iprc_checker.sv]
`include "ip_rule_classifier_core_defines.svh"

module iprc_checker #(
   parameter int RULE_COUNT = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input iprc_pkg::req_item_type req_data,
   input logic                   rsp_strobe,
   input iprc_pkg::rsp_item_type rsp_data
);

   logic accept;
   logic req_is_write;

   assign accept       = start && !busy;
   assign req_is_write = req_data.req_type == iprc_pkg::REQ_WRITE;

   `IPRC_ASSERT_DELAY(a_result_follows, clock, reset, accept, RULE_COUNT + 1, rsp_strobe)
   `IPRC_ASSERT_IMPLY(a_no_stray_result, clock, reset, rsp_strobe, $past(accept, RULE_COUNT + 1))
   `IPRC_ASSERT_DELAY(a_write_reports_zero, clock, reset, accept && req_is_write, RULE_COUNT + 1, rsp_data.matched == 1'b0 && rsp_data.class_code == iprc_pkg::CLASS_OUTSIDE)
   `IPRC_ASSERT_IMPLY(a_miss_has_no_slot, clock, reset, rsp_strobe && !rsp_data.matched, rsp_data.matched_rule == '0)
   `IPRC_ASSERT_IMPLY(a_ready_after_reset, clock, reset, !$past(reset), !busy)

endmodule

bind ip_rule_classifier_core iprc_checker #(
   .RULE_COUNT(RULE_COUNT)
) u_iprc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_strobe(rsp_strobe),
   .rsp_data  (rsp_data)
);
